[rtl/hds_pkg.sv]
// Shared constants and types for the heat diffusion stencil block.
package hds_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int MIN_SIZE   = 3;

	localparam int TEMP_W   = 24;
	localparam int COND_W   = 16;
	localparam int COND_FRAC = 12;
	localparam int ROW_W    = 12;
	localparam int COL_W    = 10;
	localparam int ADDR_W   = $clog2(MAX_WIDTH);
	localparam int WIDTH_W  = 11;
	localparam int HEIGHT_W = 13;
	localparam int SHIFT_W  = 4;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 13;

	// n+s+e+w-4t needs three more bits than a temperature, one spare for sign
	localparam int LAP_W  = TEMP_W + 4;
	localparam int PROD_W = LAP_W + COND_W + 1;

	localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TIME_SHIFT  = 2'd2;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd64;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd64;
	localparam logic [SHIFT_W-1:0]  SHIFT_RESET  = 4'd4;

	typedef logic signed [TEMP_W-1:0] temp_t;
	typedef logic [COND_W-1:0]        cond_t;
	typedef logic [ROW_W-1:0]         row_t;
	typedef logic [COL_W-1:0]         col_t;

endpackage

[rtl/hds_cell_if.sv]
// Input channel: one grid cell per transfer.
interface hds_cell_if;
	logic                  valid;
	logic                  ready;
	hds_pkg::temp_t        temperature;
	hds_pkg::cond_t        conductivity;
	hds_pkg::temp_t        source_floor;

	modport source (output valid, temperature, conductivity, source_floor, input ready);
	modport sink   (input valid, temperature, conductivity, source_floor, output ready);
endinterface

[rtl/hds_result_if.sv]
// Output channel: one updated cell with its position per transfer.
interface hds_result_if;
	logic            valid;
	logic            ready;
	hds_pkg::temp_t  new_temperature;
	hds_pkg::row_t   out_row;
	hds_pkg::col_t   out_column;
	logic            frame_end;

	modport source (output valid, new_temperature, out_row, out_column, frame_end, input ready);
	modport sink   (input valid, new_temperature, out_row, out_column, frame_end, output ready);
endinterface

[rtl/heat_diffusion_stencil_step.sv]
// One explicit heat diffusion time step over a raster-ordered grid stream.
//
// Channels: cells (sink) carries temperature, conductivity and source floor of
// one grid cell per transfer, in raster order. results (source) carries the
// updated temperature with its row, column and a frame_end flag on the last
// cell of the grid. The config port writes grid_width, grid_height and
// time_step_shift; sizes are clamped to the supported range when written.
//
// Throughput: one cell per cycle. Results leave one per cycle from the output
// register, so cells that produce two results (last column of an interior row,
// and every cell past column 0 of the last row) or three (the final cell) hold
// cells.ready low while the extra results drain. A result reaches the output
// register after the transfer of the cell that completes its window, through
// the line buffer read stage, the multiply stage, then the result register.
// Results of row r-1 come out while row r streams in.
//
// Reset: counters start at row 0, column 0, the window registers clear to zero
// and the line buffers hold nothing valid; no clearing pass is needed since
// every entry is written before it is used. When results stalls, the output
// register holds, the two internal stages fill and then cells.ready drops.
module heat_diffusion_stencil_step (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [hds_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [hds_pkg::CFG_DATA_W-1:0]   cfg_data,
	hds_cell_if.sink                         cells,
	hds_result_if.source                     results
);

	localparam int TW = hds_pkg::TEMP_W;
	localparam int PW = hds_pkg::PROD_W;
	localparam int LW = hds_pkg::LAP_W;
	localparam int WW = hds_pkg::WIDTH_W;
	localparam int HW = hds_pkg::HEIGHT_W;
	localparam int RW = hds_pkg::ROW_W;
	localparam int CW = hds_pkg::COL_W;
	localparam int AW = hds_pkg::ADDR_W;
	localparam int SHAMT_W = $clog2(hds_pkg::COND_FRAC + (1 << hds_pkg::SHIFT_W));

	// result slots of one cell, drained lowest first (matches emission order)
	localparam int SLOT_STENCIL = 0;   // cell (r-1, c-1)
	localparam int SLOT_EDGE    = 1;   // right border cell (r-1, w-1)
	localparam int SLOT_CELL    = 2;   // first or last row cell (r, c)
	localparam int SLOTS        = 3;

	// ---------------- configuration ----------------
	logic [WW-1:0]                width_q;
	logic [HW-1:0]                height_q;
	logic [hds_pkg::SHIFT_W-1:0]  shift_q;

	function automatic logic [WW-1:0] clamp_width(input logic [WW-1:0] v);
		logic [WW-1:0] r;
		r = v;
		if (v < WW'(hds_pkg::MIN_SIZE))
			r = WW'(hds_pkg::MIN_SIZE);
		else if (v > WW'(hds_pkg::MAX_WIDTH))
			r = WW'(hds_pkg::MAX_WIDTH);
		return r;
	endfunction

	function automatic logic [HW-1:0] clamp_height(input logic [HW-1:0] v);
		logic [HW-1:0] r;
		r = v;
		if (v < HW'(hds_pkg::MIN_SIZE))
			r = HW'(hds_pkg::MIN_SIZE);
		else if (v > HW'(hds_pkg::MAX_HEIGHT))
			r = HW'(hds_pkg::MAX_HEIGHT);
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= hds_pkg::WIDTH_RESET;
			height_q <= hds_pkg::HEIGHT_RESET;
			shift_q  <= hds_pkg::SHIFT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				hds_pkg::REG_GRID_WIDTH:  width_q  <= clamp_width(cfg_data[WW-1:0]);
				hds_pkg::REG_GRID_HEIGHT: height_q <= clamp_height(cfg_data[HW-1:0]);
				hds_pkg::REG_TIME_SHIFT:  shift_q  <= cfg_data[hds_pkg::SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- raster position ----------------
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic          wrap_col, row_restart, col_last, row_last;
	logic [HW-1:0] row_b;
	logic [RW-1:0] cur_row, next_row;
	logic [CW-1:0] cur_col, next_col;

	// a size written smaller than the current position restarts the row or frame
	always_comb begin
		wrap_col    = {1'b0, col_q} >= width_q;
		row_b       = wrap_col ? ({1'b0, row_q} + HW'(1)) : {1'b0, row_q};
		row_restart = row_b >= height_q;
		cur_row     = row_restart ? '0 : row_b[RW-1:0];
		cur_col     = (wrap_col || row_restart) ? '0 : col_q;
		col_last    = ({1'b0, cur_col} + WW'(1)) == width_q;
		row_last    = ({1'b0, cur_row} + HW'(1)) == height_q;
		if (col_last) begin
			next_col = '0;
			next_row = row_last ? '0 : (cur_row + RW'(1));
		end else begin
			next_col = cur_col + CW'(1);
			next_row = cur_row;
		end
	end

	logic           in_xfer;
	hds_pkg::temp_t t_in;

	assign in_xfer = cells.valid && cells.ready;
	// raise the cell to its source floor before anything else sees it
	assign t_in = (cells.temperature < cells.source_floor) ? cells.source_floor
	                                                        : cells.temperature;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_xfer) begin
			row_q <= next_row;
			col_q <= next_col;
		end
	end

	// ---------------- line buffers ----------------
	// mid_mem/cond_mem hold the row above, upper_mem the row two above. All are
	// read-before-write at the same address.
	hds_pkg::temp_t upper_mem [hds_pkg::MAX_WIDTH];
	hds_pkg::temp_t mid_mem   [hds_pkg::MAX_WIDTH];
	hds_pkg::cond_t cond_mem  [hds_pkg::MAX_WIDTH];

	logic [AW-1:0]  addr, west_addr;
	hds_pkg::temp_t north_s1, mid_rd_s1;
	hds_pkg::cond_t cond_rd_s1;

	assign addr      = AW'(cur_col);
	assign west_addr = addr - AW'(1);

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mid_mem[addr]  <= t_in;
			cond_mem[addr] <= cells.conductivity;
			// previous cell's upper-row neighbor drops into the two-above line
			if (cur_col != '0)
				upper_mem[west_addr] <= mid_rd_s1;
			north_s1 <= upper_mem[west_addr];
		end
	end

	// these reads also seed the shift windows, so they reset to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_rd_s1  <= '0;
			cond_rd_s1 <= '0;
		end else if (in_xfer) begin
			mid_rd_s1  <= mid_mem[addr];
			cond_rd_s1 <= cond_mem[addr];
		end
	end

	// ---------------- stage 1: window and product ----------------
	logic           s1_valid;
	hds_pkg::temp_t t_s1;
	logic [RW-1:0]  r_s1;
	logic [CW-1:0]  c_s1;
	logic           row_first_s1, row_ge2_s1, col_nz_s1, col_one_s1, col_last_s1, row_last_s1;

	// shift windows: west/center of the row above, south neighbor from this row,
	// center conductivity
	hds_pkg::temp_t mw0_q, mw1_q, bw0_q;
	hds_pkg::cond_t cc0_q;

	logic s2_free, s1_to_s2;

	assign s1_to_s2    = s1_valid && s2_free;
	assign cells.ready = !s1_valid || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			t_s1     <= '0;
			mw0_q    <= '0;
			mw1_q    <= '0;
			bw0_q    <= '0;
			cc0_q    <= '0;
		end else begin
			s1_valid <= in_xfer || (s1_valid && !s1_to_s2);
			if (in_xfer) begin
				t_s1  <= t_in;
				mw0_q <= mw1_q;
				mw1_q <= mid_rd_s1;
				bw0_q <= t_s1;
				cc0_q <= cond_rd_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			r_s1         <= cur_row;
			c_s1         <= cur_col;
			row_first_s1 <= cur_row == '0;
			row_ge2_s1   <= cur_row >= RW'(2);
			col_nz_s1    <= cur_col != '0;
			col_one_s1   <= cur_col == CW'(1);
			col_last_s1  <= col_last;
			row_last_s1  <= row_last;
		end
	end

	logic signed [LW-1:0]              lap;
	logic signed [hds_pkg::COND_W:0]   k_ext;
	logic signed [PW-1:0]              prod;
	logic [SLOTS-1:0]                  pend_new;

	always_comb begin
		lap = LW'(north_s1) + LW'(bw0_q) + LW'(mid_rd_s1) + LW'(mw0_q)
		      - (LW'(mw1_q) <<< 2);
		k_ext = {1'b0, cc0_q};
		prod  = PW'(k_ext) * PW'(lap);
		pend_new = '0;
		pend_new[SLOT_STENCIL] = row_ge2_s1 && col_nz_s1;
		pend_new[SLOT_EDGE]    = row_ge2_s1 && col_nz_s1 && col_last_s1;
		pend_new[SLOT_CELL]    = row_first_s1 || row_last_s1;
	end

	// ---------------- stage 2: round, scale, saturate, drain ----------------
	logic [SLOTS-1:0]     pend_s2;
	logic signed [PW-1:0] prod_s2;
	hds_pkg::temp_t       cen_s2, east_s2, tx_s2;
	logic                 pass_s2, fend_s2;
	logic [RW-1:0]        r_s2;
	logic [CW-1:0]        c_s2;

	// output register takes one slot per cycle while it is empty or results is ready
	logic             out_valid_q, out_load, single;
	logic [SLOTS-1:0] take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_s2 <= '0;
		else if (s1_to_s2)
			pend_s2 <= pend_new;
		else if (out_load)
			pend_s2 <= pend_s2 & ~take;
	end

	always_ff @(posedge clk) begin
		if (s1_to_s2) begin
			prod_s2 <= prod;
			cen_s2  <= mw1_q;
			east_s2 <= mid_rd_s1;
			tx_s2   <= t_s1;
			pass_s2 <= col_one_s1;
			fend_s2 <= row_last_s1 && col_last_s1;
			r_s2    <= r_s1;
			c_s2    <= c_s1;
		end
	end

	logic [SHAMT_W-1:0]   shamt;
	logic signed [PW-1:0] rounded, delta, updated;
	hds_pkg::temp_t       sat_val;

	// delta = floor((k*L + 2^(11+shift)) / 2^(12+shift)), round half up
	always_comb begin
		shamt   = SHAMT_W'(hds_pkg::COND_FRAC) + SHAMT_W'(shift_q);
		rounded = prod_s2 + (PW'(1) <<< (shamt - SHAMT_W'(1)));
		delta   = rounded >>> shamt;
		updated = delta + PW'(cen_s2);
		if (updated[PW-1:TW-1] == '0 || updated[PW-1:TW-1] == '1)
			sat_val = updated[TW-1:0];
		else if (updated[PW-1])
			sat_val = {1'b1, {(TW-1){1'b0}}};
		else
			sat_val = {1'b0, {(TW-1){1'b1}}};
	end

	hds_pkg::temp_t   sel_temp;
	logic [RW-1:0]    sel_row;
	logic [CW-1:0]    sel_col;
	logic             sel_fend;

	always_comb begin
		take     = pend_s2 & (~pend_s2 + SLOTS'(1));
		single   = (pend_s2 & (pend_s2 - SLOTS'(1))) == '0;
		out_load = (pend_s2 != '0) && (!out_valid_q || results.ready);
		s2_free  = (pend_s2 == '0) || (out_load && single);
		if (pend_s2[SLOT_STENCIL]) begin
			sel_temp = pass_s2 ? cen_s2 : sat_val;
			sel_row  = r_s2 - RW'(1);
			sel_col  = c_s2 - CW'(1);
			sel_fend = 1'b0;
		end else if (pend_s2[SLOT_EDGE]) begin
			sel_temp = east_s2;
			sel_row  = r_s2 - RW'(1);
			sel_col  = c_s2;
			sel_fend = 1'b0;
		end else begin
			sel_temp = tx_s2;
			sel_row  = r_s2;
			sel_col  = c_s2;
			sel_fend = fend_s2;
		end
	end

	hds_pkg::temp_t out_temp_q;
	logic [RW-1:0]  out_row_q;
	logic [CW-1:0]  out_col_q;
	logic           out_fend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (results.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_temp_q <= sel_temp;
			out_row_q  <= sel_row;
			out_col_q  <= sel_col;
			out_fend_q <= sel_fend;
		end
	end

	assign results.valid           = out_valid_q;
	assign results.new_temperature = out_temp_q;
	assign results.out_row         = out_row_q;
	assign results.out_column      = out_col_q;
	assign results.frame_end       = out_fend_q;

endmodule

[rtl/hds_checker.sv]
// Port-level checks for the heat diffusion stencil block, bound to the top level.
module hds_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            cells_ready,
	input logic            result_valid,
	input logic            result_ready,
	input hds_pkg::temp_t  new_temperature,
	input hds_pkg::row_t   out_row,
	input hds_pkg::col_t   out_column,
	input logic            frame_end
);

	// a stalled result holds its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(new_temperature)
			&& $stable(out_row) && $stable(out_column) && $stable(frame_end))
		else $error("result changed while stalled");

	// the grid is at least three by three, so the last cell sits past row and column one
	a_frame_end_pos: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_end |-> out_row >= 12'd2 && out_column >= 10'd2)
		else $error("frame_end on a cell that cannot be last");

	// nothing leaves right after reset and a cell can be taken at once
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !result_valid && cells_ready)
		else $error("block not empty after reset");

	// an input stall with the output register idle is always followed by a valid result
	a_no_dead_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!cells_ready && !result_valid |=> result_valid)
		else $error("input stalled while output idle");

endmodule

bind heat_diffusion_stencil_step hds_checker u_hds_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cells_ready     (cells.ready),
	.result_valid    (results.valid),
	.result_ready    (results.ready),
	.new_temperature (results.new_temperature),
	.out_row         (results.out_row),
	.out_column      (results.out_column),
	.frame_end       (results.frame_end)
);
